[rtl/core/bcc_pkg.sv]
// Shared types and constants for the button click classifier.
// No dependencies; bcc_lane, bcc_merge and the top level import this package.
package bcc_pkg;

  localparam int unsigned NumButtonsDef = 4;
  localparam int unsigned MaxButtons    = 4;

  localparam int unsigned TimeoutW = 16;
  localparam int unsigned MaskW    = 4;
  localparam int unsigned PeriodW  = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PinsW    = 4;
  localparam int unsigned BtnIdxW  = 2;

  localparam logic [TimeoutW-1:0] TimeoutRst = TimeoutW'(300);
  localparam logic [MaskW-1:0]    MaskRst    = '0;
  localparam logic [PeriodW-1:0]  PeriodRst  = PeriodW'(10);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegTimeout0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMask     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPeriod   = 3'd5;

  // operation codes of an input item
  localparam logic OpTick = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_SINGLE  = 3'd1,
    EV_DOUBLE  = 3'd2,
    EV_HOLD    = 3'd3,
    EV_RELEASE = 3'd4
  } event_e;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_ONCE     = 5'b00010,
    ST_RELEASED = 5'b00100,
    ST_TWICE    = 5'b01000,
    ST_HELD     = 5'b10000
  } click_state_e;

  // per-lane strobes for one accepted item
  typedef struct packed {
    logic tick;
    logic pressed;
    logic clear;
  } lane_ctrl_t;

endpackage

[rtl/core/bcc_in_if.sv]
// Input channel of the button click classifier: valid/ready plus item payload.
// Standalone; no package needed.
interface bcc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [3:0] pin_levels;
  logic [1:0] button_index;

  modport source (output valid, op, pin_levels, button_index, input ready);
  modport sink   (input valid, op, pin_levels, button_index, output ready);
endinterface

[rtl/core/bcc_out_if.sv]
// Result channel of the button click classifier: valid/ready plus event code.
// Standalone; no package needed.
interface bcc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;

  modport source (output valid, event_code, input ready);
  modport sink   (input valid, event_code, output ready);
endinterface

[rtl/core/bcc_lane.sv]
// One button's five-state click classifier with its timeout register.
// Depends on bcc_pkg.
module bcc_lane (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bcc_pkg::lane_ctrl_t             ctrl_i,
  input  logic                            to_we_i,
  input  logic [bcc_pkg::TimeoutW-1:0]    to_data_i,
  input  logic [bcc_pkg::PeriodW-1:0]     period_i,
  output bcc_pkg::event_e                 pend_o
);
  import bcc_pkg::*;

  click_state_e        state_q, state_d;
  logic [TimeoutW-1:0] elapsed_q, elapsed_d;
  logic [TimeoutW-1:0] timeout_q;
  event_e              pend_q, pend_d;
  logic [TimeoutW:0]   sum;
  logic [TimeoutW-1:0] sat;
  logic                expired;

  assign sum     = {1'b0, elapsed_q} + {{(TimeoutW+1-PeriodW){1'b0}}, period_i};
  assign sat     = sum[TimeoutW] ? {TimeoutW{1'b1}} : sum[TimeoutW-1:0];
  assign expired = sat >= timeout_q;

  always_comb begin
    state_d   = state_q;
    elapsed_d = elapsed_q;
    pend_d    = pend_q;
    if (ctrl_i.tick) begin
      unique case (state_q)
        ST_IDLE: begin
          if (ctrl_i.pressed) begin
            elapsed_d = '0;
            state_d   = ST_ONCE;
          end
        end
        ST_ONCE: begin
          elapsed_d = sat;
          if (expired) state_d = ST_HELD;
          if (!ctrl_i.pressed) state_d = ST_RELEASED;
        end
        ST_RELEASED: begin
          elapsed_d = sat;
          if (expired) begin
            pend_d  = EV_SINGLE;
            state_d = ST_IDLE;
          end
          if (ctrl_i.pressed) begin
            elapsed_d = '0;
            state_d   = ST_TWICE;
          end
        end
        ST_TWICE: begin
          elapsed_d = sat;
          if (expired) state_d = ST_HELD;
          if (!ctrl_i.pressed) begin
            pend_d  = EV_DOUBLE;
            state_d = ST_IDLE;
          end
        end
        ST_HELD: begin
          pend_d = EV_HOLD;
          if (!ctrl_i.pressed) begin
            pend_d  = EV_RELEASE;
            state_d = ST_IDLE;
          end
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
    // a read of this button drains its pending event
    if (ctrl_i.clear) pend_d = EV_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      elapsed_q <= '0;
      pend_q    <= EV_NONE;
      timeout_q <= TimeoutRst;
    end else begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
      pend_q    <= pend_d;
      if (to_we_i) timeout_q <= to_data_i;
    end
  end

  assign pend_o = pend_q;

endmodule

[rtl/core/bcc_merge.sv]
// Merge stage: picks the addressed lane's pending event and holds it in the
// result register until the sink takes it. Depends on bcc_pkg.
module bcc_merge #(
  parameter int unsigned NUM_BUTTONS = bcc_pkg::NumButtonsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bcc_pkg::event_e                pend_i [NUM_BUTTONS],
  input  logic                           rd_i,
  input  logic [bcc_pkg::BtnIdxW-1:0]    rd_idx_i,
  output logic                           slot_free_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2:0]                     out_event_o
);
  import bcc_pkg::*;

  event_e rd_evt;
  event_e evt_q, evt_d;
  logic   vld_q, vld_d;

  // buttons past the lane count read as no event
  always_comb begin
    rd_evt = EV_NONE;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (rd_idx_i == BtnIdxW'(b)) rd_evt = pend_i[b];
    end
  end

  assign slot_free_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    evt_d = evt_q;
    if (rd_i) begin
      vld_d = 1'b1;
      evt_d = rd_evt;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    evt_q <= evt_d;
  end

  assign out_valid_o = vld_q;
  assign out_event_o = evt_q;

endmodule

[rtl/core/button_click_classifier_top.sv]
// Top level of the button click classifier: config registers, one lane per
// button and the merge stage. Depends on bcc_pkg, bcc_in_if, bcc_out_if,
// bcc_lane and bcc_merge.
//
//  channel   | direction | payload                          | transfer when
//  ----------+-----------+----------------------------------+--------------------
//  in_i      | sink      | op, pin_levels[3:0], button_index | valid && ready
//  out_o     | source    | event_code[2:0]                  | valid && ready
//  cfg       | write     | cfg_idx_i[2:0], cfg_data_i[15:0] | cfg_we_i
//
// One item per cycle while input ready is high. A tick updates every lane in the
// cycle it transfers; a read selects the addressed lane's pending event into the
// result register and clears it, so the result appears in the cycle after the
// read transfer. The only stall source is the single result register: input
// ready drops while a result waits and the sink holds ready low. Reset clears
// all lanes to idle with no pending event and loads the register reset values.
module button_click_classifier_top #(
  parameter int unsigned NUM_BUTTONS = bcc_pkg::NumButtonsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bcc_in_if.sink                        in_i,
  bcc_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [bcc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bcc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bcc_pkg::*;

  logic [MaskW-1:0]   mask_q;
  logic [PeriodW-1:0] period_q;
  logic               in_fire;
  logic               tick;
  logic               rd;
  logic               slot_free;
  event_e             pend [NUM_BUTTONS];

  // shared config: active level mask and tick period
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= MaskRst;
      period_q <= PeriodRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegMask)   mask_q   <= cfg_data_i[MaskW-1:0];
      if (cfg_idx_i == RegPeriod) period_q <= cfg_data_i[PeriodW-1:0];
    end
  end

  // accept while the result register is free or draining this cycle
  assign in_i.ready = slot_free;
  assign in_fire    = in_i.valid && slot_free;
  assign tick       = in_fire && (in_i.op == OpTick);
  assign rd         = in_fire && (in_i.op == OpRead);

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    lane_ctrl_t ctrl;
    logic       to_we;

    assign ctrl.tick    = tick;
    // pressed when the pin matches that button's active level
    assign ctrl.pressed = (in_i.pin_levels[b] == mask_q[b]);
    assign ctrl.clear   = rd && (in_i.button_index == BtnIdxW'(b));
    assign to_we        = cfg_we_i && (cfg_idx_i == (RegTimeout0 + CfgIdxW'(b)));

    bcc_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .to_we_i   (to_we),
      .to_data_i (cfg_data_i[TimeoutW-1:0]),
      .period_i  (period_q),
      .pend_o    (pend[b])
    );
  end

  bcc_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pend_i      (pend),
    .rd_i        (rd),
    .rd_idx_i    (in_i.button_index),
    .slot_free_o (slot_free),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_event_o (out_o.event_code)
  );

endmodule
